/* sv/lztc_pkg.sv */
// ----------------------------------------------------------------------------
// lztc_pkg
// Shared types and constants of the triple-code decompressor.
// ----------------------------------------------------------------------------
package lztc_pkg;

    // History window and result framing.
    localparam int HIST_SIZE        = 1024;
    localparam int HIST_AW          = 10;
    localparam int MAX_RESULTS      = 64;
    localparam int MAX_LANES        = 4;
    localparam int DEF_BYTES_PER_RESULT = 4;
    localparam int EMIT_CNT_W       = 9;
    localparam int STEP_W           = 9;
    localparam int QUEUE_AW         = 2;

    // Group decoding masks.
    localparam logic [7:0] TOP_BIT   = 8'd128;
    localparam logic [7:0] LOW7_MASK = 8'd127;
    localparam logic [7:0] LEN_MASK  = 8'd31;
    localparam logic [7:0] OFS_MASK  = 8'd224;
    localparam logic [HIST_AW-1:0] DELETE_FIELD = 10'd1;

    // What one group asks the back end to do.
    typedef enum logic [2:0] {
        K_NONE,
        K_DELETE,
        K_RAW,
        K_REPEAT,
        K_MATCH
    } t_kind;

    // Classified group as it travels from front to back.
    typedef struct packed {
        t_kind              kind;
        logic [7:0]         g0;
        logic [7:0]         g1;
        logic [7:0]         g2;
        logic [STEP_W-1:0]  total;
        logic [4:0]         len;
        logic [HIST_AW-1:0] field;
        logic               fin;
    } t_cmd;

    // One result as it waits for the consumer.
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        logic [2:0] cnt;
        logic       run_end;
        logic       stream_end;
    } t_result;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_COPY,
        S_PUSH,
        S_FLUSH,
        S_END
    } t_state;

endpackage

/* sv/lztc_queue.sv */
// ----------------------------------------------------------------------------
// lztc_queue
// Small register FIFO used between front and back and at the result side.
// ----------------------------------------------------------------------------
module lztc_queue
    import lztc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int AW    = QUEUE_AW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int DEPTH = 2 ** AW;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* sv/lztc_front.sv */
// ----------------------------------------------------------------------------
// lztc_front
// Classifies each group into a command and tracks raw-run framing.
// ----------------------------------------------------------------------------
module lztc_front
    import lztc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_group_first,
    input  logic [7:0] i_group_second,
    input  logic [7:0] i_group_third,
    input  logic       i_final_group,
    output t_cmd       o_cmd
);

    logic [HIST_AW-1:0] r_raw_rem;
    logic [HIST_AW-1:0] n_raw_rem;
    logic [HIST_AW-1:0] field;
    logic [4:0]         len;
    logic [7:0]         pairs;
    logic [1:0]         raw_n;

    assign field = {i_group_first[6:0], 3'((i_group_second & OFS_MASK) >> 5)};
    assign len   = 5'(i_group_second & LEN_MASK);
    assign pairs = {1'b0, 7'(i_group_first & LOW7_MASK)} + 8'd1;
    assign raw_n = (r_raw_rem < HIST_AW'(3)) ? r_raw_rem[1:0] : 2'd3;

    // Decode the group according to the run state.
    always_comb begin
        o_cmd       = '0;
        o_cmd.g0    = i_group_first;
        o_cmd.g1    = i_group_second;
        o_cmd.g2    = i_group_third;
        o_cmd.len   = len;
        o_cmd.field = field;
        o_cmd.fin   = i_final_group;
        o_cmd.kind  = K_NONE;
        n_raw_rem   = r_raw_rem;
        if (r_raw_rem != '0) begin
            o_cmd.kind  = K_RAW;
            o_cmd.total = STEP_W'(raw_n);
            n_raw_rem   = r_raw_rem - HIST_AW'(raw_n);
        end else if ((i_group_first & TOP_BIT) != '0) begin
            o_cmd.kind  = K_REPEAT;
            o_cmd.total = {pairs, 1'b0};
        end else if (len != '0 || (i_group_first == '0 && i_group_second == '0)) begin
            o_cmd.kind  = K_MATCH;
            o_cmd.total = STEP_W'(len) + 1'b1;
        end else if (field == DELETE_FIELD) begin
            o_cmd.kind  = K_DELETE;
        end else begin
            n_raw_rem   = field;
        end
        if (i_final_group) begin
            n_raw_rem = '0;
        end
    end

    // Raw-run counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_rem <= '0;
        end else if (i_accept) begin
            r_raw_rem <= n_raw_rem;
        end
    end

endmodule

/* sv/lztc_back.sv */
// ----------------------------------------------------------------------------
// lztc_back
// Executes commands byte by byte against the history and packs results.
// ----------------------------------------------------------------------------
module lztc_back
    import lztc_pkg::*;
#(
    parameter int LANES = MAX_LANES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_valid,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int CAP = MAX_RESULTS * LANES;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [HIST_AW-1:0] r_wp, n_wp;
    logic               r_hv, n_hv;
    logic [7:0]         r_held, n_held;
    logic               r_wrapped, n_wrapped;
    logic [7:0]         r_lane [MAX_LANES];
    logic [7:0]         n_lane [MAX_LANES];
    logic [2:0]         r_lane_cnt, n_lane_cnt;
    logic [EMIT_CNT_W-1:0] r_emit_cnt, n_emit_cnt;

    logic [7:0]         r_mem [HIST_SIZE];
    logic [7:0]         r_rdata;
    logic               r_rd_held;
    logic               r_rd_zero;

    logic [HIST_AW-1:0] rd_addr;
    logic               rd_en;
    logic               push_req;
    logic               commit_req;
    logic               commit;
    logic [7:0]         push_b;
    logic [7:0]         copy_b;
    logic [7:0]         lit_b;
    t_state             done_state;
    logic               last_result;

    assign rd_addr = r_wp + HIST_AW'(r_hv) + r_cmd.field;
    assign copy_b  = r_rd_held ? r_held : (r_rd_zero ? 8'd0 : r_rdata);
    assign done_state = r_cmd.fin ? S_FLUSH : S_END;

    // Byte of the current step for raw, repeat and literal pushes.
    always_comb begin
        lit_b = r_cmd.g2;
        case (r_cmd.kind)
            K_RAW: begin
                if (r_step == '0) begin
                    lit_b = r_cmd.g0;
                end else if (r_step == STEP_W'(1)) begin
                    lit_b = r_cmd.g1;
                end
            end
            K_REPEAT: lit_b = r_step[0] ? r_cmd.g2 : r_cmd.g1;
            default:  lit_b = r_cmd.g2;
        endcase
    end

    // State register and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp       <= '0;
            r_hv       <= 1'b0;
            r_wrapped  <= 1'b0;
            r_lane_cnt <= '0;
            r_emit_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_wp       <= n_wp;
            r_hv       <= n_hv;
            r_wrapped  <= n_wrapped;
            r_lane_cnt <= n_lane_cnt;
            r_emit_cnt <= n_emit_cnt;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_step <= n_step;
        r_held <= n_held;
        r_lane <= n_lane;
    end

    // History memory: one write port for commits, one registered read port.
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_mem[r_wp] <= r_held;
        end
        if (rd_en) begin
            r_rdata   <= r_mem[rd_addr];
            r_rd_held <= r_hv && (rd_addr == r_wp);
            r_rd_zero <= !r_wrapped && (rd_addr >= r_wp);
        end
    end

    // Next state, byte pushes, commits and result packing.
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_step     = r_step;
        n_wp       = r_wp;
        n_hv       = r_hv;
        n_held     = r_held;
        n_wrapped  = r_wrapped;
        n_lane     = r_lane;
        n_lane_cnt = r_lane_cnt;
        n_emit_cnt = r_emit_cnt;
        o_cmd_pop  = 1'b0;
        rd_en      = 1'b0;
        push_req   = 1'b0;
        commit_req = 1'b0;
        push_b     = lit_b;
        last_result = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_step    = '0;
                    unique case (i_cmd.kind)
                        K_DELETE: begin
                            n_hv    = 1'b0;
                            n_state = i_cmd.fin ? S_FLUSH : S_END;
                        end
                        K_NONE:   n_state = i_cmd.fin ? S_FLUSH : S_END;
                        K_MATCH:  n_state = (i_cmd.len == '0) ? S_PUSH : S_ADDR;
                        K_RAW, K_REPEAT: n_state = S_PUSH;
                        default:  n_state = S_END;
                    endcase
                end
            end
            S_ADDR: begin
                rd_en   = 1'b1;
                n_state = S_COPY;
            end
            S_COPY: begin
                if (!i_res_full) begin
                    push_req = 1'b1;
                    push_b   = copy_b;
                    n_step   = r_step + 1'b1;
                    n_state  = (r_step + 1'b1 == STEP_W'(r_cmd.len)) ? S_PUSH : S_ADDR;
                end
            end
            S_PUSH: begin
                if (!i_res_full) begin
                    push_req = 1'b1;
                    n_step   = r_step + 1'b1;
                    if (r_step + 1'b1 == r_cmd.total) begin
                        n_state = done_state;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_res_full) begin
                    commit_req = 1'b1;
                    n_state    = S_END;
                end
            end
            S_END: begin
                if (!i_res_full) begin
                    last_result = 1'b1;
                    n_lane_cnt  = '0;
                    n_emit_cnt  = '0;
                    n_state     = S_IDLE;
                    if (r_cmd.fin) begin
                        n_wp      = '0;
                        n_hv      = 1'b0;
                        n_wrapped = 1'b0;
                        n_held    = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Committing the held byte writes history and, below the result cap, packs it into a lane.
        commit = r_hv && (push_req || commit_req);
        if (commit) begin
            n_wp = r_wp + 1'b1;
            if (r_wp == '1) begin
                n_wrapped = 1'b1;
            end
            if (r_emit_cnt < EMIT_CNT_W'(CAP)) begin
                n_emit_cnt = r_emit_cnt + 1'b1;
                if (r_lane_cnt == 3'(LANES)) begin
                    n_lane_cnt = 3'd1;
                    n_lane[0]  = r_held;
                end else begin
                    n_lane[r_lane_cnt[1:0]] = r_held;
                    n_lane_cnt = r_lane_cnt + 1'b1;
                end
            end
        end
        if (push_req) begin
            n_held = push_b;
            n_hv   = 1'b1;
        end
        if (commit_req) begin
            n_hv = 1'b0;
        end
    end

    // A full lane buffer leaves when the next byte arrives or the group ends.
    assign o_res_push = last_result ||
                        (commit && r_emit_cnt < EMIT_CNT_W'(CAP) &&
                         r_lane_cnt == 3'(LANES));

    always_comb begin
        o_res            = '0;
        o_res.a          = (r_lane_cnt > 3'd0) ? r_lane[0] : 8'd0;
        o_res.b          = (r_lane_cnt > 3'd1) ? r_lane[1] : 8'd0;
        o_res.c          = (r_lane_cnt > 3'd2) ? r_lane[2] : 8'd0;
        o_res.d          = (r_lane_cnt > 3'd3) ? r_lane[3] : 8'd0;
        o_res.cnt        = r_lane_cnt;
        o_res.run_end    = last_result;
        o_res.stream_end = last_result && r_cmd.fin;
    end

    // The lane buffer never holds more than one result.
    a_lane_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lane_cnt <= 3'(LANES))
        else $error("lane count beyond result width");

    // The end of a final group leaves the history empty and nothing held.
    a_stream_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && !i_res_full && r_cmd.fin) |=> (r_wp == '0 && !r_hv))
        else $error("stream state not cleared after final group");

    // A result is only pushed when the result queue has room.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    // Each group ends with exactly one closing result before the next command.
    a_close_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.run_end) |=> (r_state == S_IDLE && r_lane_cnt == '0))
        else $error("group not closed cleanly");

endmodule

/* sv/lz_triple_code_decompressor.sv */
// Flow: an accepted group is written to the command queue, which the back end reads;
//   each history copy byte passes through S_ADDR (registered read) and then S_COPY.
// Byte pushes in S_PUSH and S_COPY wait while the result queue is full; each group
//   then passes S_END, a final group S_FLUSH first, over the 1-read/1-write history RAM.
// Reset: synchronous, active low; history reads as zero until written.
// ----------------------------------------------------------------------------
// lz_triple_code_decompressor
// Decodes 3-byte LZ groups into packed results of up to four bytes.
// ----------------------------------------------------------------------------
module lz_triple_code_decompressor
    import lztc_pkg::*;
#(
    parameter int BYTES_PER_RESULT = DEF_BYTES_PER_RESULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_group_first,
    input  logic [7:0] i_group_second,
    input  logic [7:0] i_group_third,
    input  logic       i_final_group,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_a,
    output logic [7:0] o_out_b,
    output logic [7:0] o_out_c,
    output logic [7:0] o_out_d,
    output logic [2:0] o_byte_count,
    output logic       o_run_end,
    output logic       o_stream_end
);

    localparam int LANES = (BYTES_PER_RESULT > MAX_LANES) ? MAX_LANES : BYTES_PER_RESULT;

    t_cmd    front_cmd;
    t_cmd    q_cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    logic    res_full;
    logic    res_push;
    t_result back_res;
    t_result head_res;
    logic    accept;

    assign accept = push && !full;

    // Front: classify groups.
    lztc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_group_first  (i_group_first),
        .i_group_second (i_group_second),
        .i_group_third  (i_group_third),
        .i_final_group  (i_final_group),
        .o_cmd          (front_cmd)
    );

    // Command queue between front and back.
    lztc_queue #(.WIDTH($bits(t_cmd)), .AW(QUEUE_AW)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (cmd_pop),
        .o_data  (q_cmd),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    // Back: execute against the history.
    lztc_back #(.LANES(LANES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    // Result queue toward the consumer.
    lztc_queue #(.WIDTH($bits(t_result)), .AW(QUEUE_AW)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .i_pop   (pop),
        .o_data  (head_res),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_out_a      = head_res.a;
    assign o_out_b      = head_res.b;
    assign o_out_c      = head_res.c;
    assign o_out_d      = head_res.d;
    assign o_byte_count = head_res.cnt;
    assign o_run_end    = head_res.run_end;
    assign o_stream_end = head_res.stream_end;

endmodule
